// File: rtl/flbt_pkg.sv
// flbt_pkg: shared types, constants and helpers for the failed-login ban table
// used by flbt_cell and failed_login_ban_table_unit; no dependencies
package flbt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_TIME  = 2'd2;

    localparam logic [7:0]  RST_MAX_ATTEMPTS  = 8'd5;
    localparam logic [15:0] RST_EXPIRE_WINDOW = 16'd300;
    localparam logic [15:0] RST_PENALTY_TIME  = 16'd60;

    localparam logic       CMD_FAIL  = 1'b0;
    localparam logic       CMD_PURGE = 1'b1;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_BANNED   = 3'd2,
        ST_FULL     = 3'd3,
        ST_PURGED   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  max_attempts;
        logic [15:0] expire_window;
        logic [15:0] penalty_time;
    } t_cfg;

    // token that walks the chain, one cell per cycle
    typedef struct packed {
        logic             vld;
        logic             cmd;
        logic [63:0]      addr_high;
        logic [63:0]      addr_low;
        logic [7:0]       rep;
        logic [31:0]      now;
        logic             hit;
        logic             banned;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] purged;
        logic [CNT_W-1:0] occ;
    } t_tok;

    // insert request broadcast to all cells at the end of a scan
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [63:0]      addr_high;
        logic [63:0]      addr_low;
        logic [31:0]      now;
    } t_ins;

    // 32-bit time add that saturates at all ones
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: rtl/flbt_cell.sv
// flbt_cell: one table entry plus the token stage that passes it on
// depends on flbt_pkg
module flbt_cell
    import flbt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cfg             i_cfg,
    input  t_tok             i_tok,
    input  t_ins             i_ins,
    output t_tok             o_tok
);

    logic        r_valid;
    logic [63:0] r_addr_high;
    logic [63:0] r_addr_low;
    logic [7:0]  r_attempts;
    logic [31:0] r_expiry;
    t_tok        r_tok;

    logic        n_valid;
    logic [7:0]  n_attempts;
    logic [31:0] n_expiry;
    t_tok        n_tok;
    logic [8:0]  sum;
    logic        match;
    logic        take;

    always_comb begin
        n_valid    = r_valid;
        n_attempts = r_attempts;
        n_expiry   = r_expiry;
        n_tok      = i_tok;
        sum        = {1'b0, r_attempts} + {1'b0, i_tok.rep};
        match      = r_valid && !i_tok.hit && (r_addr_high == i_tok.addr_high)
                     && (r_addr_low == i_tok.addr_low);
        take       = i_ins.en && (i_ins.idx == i_idx);
        if (i_tok.vld) begin
            if (i_tok.cmd == CMD_PURGE) begin
                if (r_valid && (r_expiry <= i_tok.now)) begin
                    n_valid      = 1'b0;
                    n_tok.purged = i_tok.purged + CNT_W'(1);
                end
            end else begin
                if (match) begin
                    n_tok.hit = 1'b1;
                    if (sum >= {1'b0, i_cfg.max_attempts}) begin
                        n_valid      = 1'b0;
                        n_tok.banned = 1'b1;
                    end else begin
                        n_attempts = sum[7:0];
                        n_expiry   = sat_add(r_expiry, i_cfg.penalty_time);
                    end
                end
                if (!r_valid && !i_tok.free_found) begin
                    n_tok.free_found = 1'b1;
                    n_tok.free_idx   = i_idx;
                end
            end
            n_tok.occ = i_tok.occ + CNT_W'(n_valid);
        end
        if (take) begin
            n_valid    = 1'b1;
            n_attempts = 8'd1;
            n_expiry   = sat_add(i_ins.now, i_cfg.expire_window);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_attempts <= n_attempts;
        r_expiry   <= n_expiry;
        if (take) begin
            r_addr_high <= i_ins.addr_high;
            r_addr_low  <= i_ins.addr_low;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/failed_login_ban_table_unit.sv
// failed_login_ban_table_unit: top level, chain of table cells plus finish logic
// depends on flbt_pkg and flbt_cell
//
// channel   direction  transfer when          payload
// -------   ---------  ---------------------  ------------------------------------
// command   in         start && !busy         i_cmd i_addr_high i_addr_low
//                                             i_repeat_count i_now
// result    out        o_done (one cycle)     o_status o_ban_high o_ban_low
//                                             o_purged_count o_occupancy
// config    in         i_cfg_we               i_cfg_idx i_cfg_data
//
// an accepted command walks the row of TABLE_DEPTH cells, one cell per cycle;
// the result strobe follows the token out of the last cell through the done register,
// and a new command cannot be taken before the previous one has left the cell
// chain
// busy is high from the transfer until the last cell hands back the token;
// a start during the strobe cycle is taken
// synchronous active-low reset empties the table and loads register defaults
// the result receiver cannot stall: o_done is high for exactly one cycle
module failed_login_ban_table_unit
    import flbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cmd,
    input  logic [63:0]           i_addr_high,
    input  logic [63:0]           i_addr_low,
    input  logic [7:0]            i_repeat_count,
    input  logic [31:0]           i_now,
    output logic                  o_done,
    output logic [2:0]            o_status,
    output logic [63:0]           o_ban_high,
    output logic [63:0]           o_ban_low,
    output logic [4:0]            o_purged_count,
    output logic [4:0]            o_occupancy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_attempts  <= RST_MAX_ATTEMPTS;
            r_cfg.expire_window <= RST_EXPIRE_WINDOW;
            r_cfg.penalty_time  <= RST_PENALTY_TIME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_ATTEMPTS:  r_cfg.max_attempts  <= i_cfg_data[7:0];
                CFG_EXPIRE_WINDOW: r_cfg.expire_window <= i_cfg_data[15:0];
                CFG_PENALTY_TIME:  r_cfg.penalty_time  <= i_cfg_data[15:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // token chain: w_tok[0] is the entering command, w_tok[TABLE_DEPTH] the last cell
    t_tok w_tok [TABLE_DEPTH+1];
    t_ins w_ins;
    logic accept;
    t_tok last;

    assign accept = start && !busy;

    always_comb begin
        w_tok[0]            = '0;
        w_tok[0].vld        = accept;
        w_tok[0].cmd        = i_cmd;
        w_tok[0].addr_high  = i_addr_high;
        w_tok[0].addr_low   = i_addr_low;
        w_tok[0].rep        = i_repeat_count;
        w_tok[0].now        = i_now;
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        flbt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_cfg   (r_cfg),
            .i_tok   (w_tok[g]),
            .i_ins   (w_ins),
            .o_tok   (w_tok[g+1])
        );
    end

    assign last = w_tok[TABLE_DEPTH];

    // finish: a miss with a free slot inserts into the lowest free cell
    logic             ins_go;
    t_status          n_status;
    logic [CNT_W-1:0] n_occ;
    logic [31:0]      occ_wide;
    logic [31:0]      purged_wide;

    assign ins_go = last.vld && (last.cmd == CMD_FAIL) && !last.hit && last.free_found;

    always_comb begin
        w_ins.en        = ins_go;
        w_ins.idx       = last.free_idx;
        w_ins.addr_high = last.addr_high;
        w_ins.addr_low  = last.addr_low;
        w_ins.now       = last.now;
    end

    always_comb begin
        if (last.cmd == CMD_PURGE) begin
            n_status = ST_PURGED;
        end else if (last.hit) begin
            n_status = last.banned ? ST_BANNED : ST_UPDATED;
        end else if (last.free_found) begin
            n_status = ST_INSERTED;
        end else begin
            n_status = ST_FULL;
        end
        n_occ       = last.occ + CNT_W'(ins_go);
        occ_wide    = 32'(n_occ);
        purged_wide = 32'(last.purged);
    end

    // control: busy from transfer until the token leaves the last cell
    logic r_busy;
    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= last.vld;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last.vld) begin
                r_busy <= 1'b0;
            end
        end
    end

    // result payload registers
    t_status     r_status;
    logic [63:0] r_ban_high;
    logic [63:0] r_ban_low;
    logic [4:0]  r_purged;
    logic [4:0]  r_occ;

    always_ff @(posedge i_clk) begin
        if (last.vld) begin
            r_status   <= n_status;
            r_ban_high <= (n_status == ST_BANNED) ? last.addr_high : 64'd0;
            r_ban_low  <= (n_status == ST_BANNED) ? last.addr_low : 64'd0;
            r_purged   <= (last.cmd == CMD_PURGE) ? purged_wide[4:0] : 5'd0;
            r_occ      <= occ_wide[4:0];
        end
    end

    assign busy           = r_busy;
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_ban_high     = r_ban_high;
    assign o_ban_low      = r_ban_low;
    assign o_purged_count = r_purged;
    assign o_occupancy    = r_occ;

endmodule
